// File: sv/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
package lsc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int DIM_W          = 13;
    localparam int FMT_W          = 3;
    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_UNSUP  = 2'd2
    } t_status;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    localparam logic [FMT_W-1:0] FMT_15BIT = 3'd1;
    localparam logic [FMT_W-1:0] FMT_24BIT = 3'd3;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [FMT_W-1:0] FORMAT_RST = 3'd2;

endpackage

// File: sv/lsc_if.sv
// Segment input and clipped result channel interfaces.
interface lsc_seg_if #(parameter int N = 16) ();
    logic                valid;
    logic                ready;
    logic signed [N-1:0] start_x;
    logic signed [N-1:0] start_y;
    logic signed [N-1:0] end_x;
    logic signed [N-1:0] end_y;
    modport source(output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_clip_if #(parameter int N = 16) ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic signed [N-1:0] clip_x1;
    logic signed [N-1:0] clip_y1;
    logic signed [N-1:0] clip_x2;
    logic signed [N-1:0] clip_y2;
    modport source(output valid, status, clip_x1, clip_y1, clip_x2, clip_y2, input ready);
    modport sink(input valid, status, clip_x1, clip_y1, clip_x2, clip_y2, output ready);
endinterface

// File: sv/line_segment_clipper_unit.sv
// Line segment clipper top level: register port, front end, queue, clipping pipeline.
//
//  channel   dir  handshake            word
//  i_seg     in   valid/ready          start_x, start_y, end_x, end_y
//  o_clip    out  valid/ready          status, clip_x1, clip_y1, clip_x2, clip_y2
//  apb       in   psel/penable/pready  raster_width, raster_height, pixel_format
//
// One segment per cycle sustained while the output is not stalled. From acceptance a
// segment passes the queue, the x multiply register, two divider pipelines of
// 2*(COORD_BITS+2) steps each, the x adjust register, the y multiply register and
// one output register.
// Reset is synchronous, active low; it empties the queue and all valid bits.
// A stalled output freezes the whole pipeline; the 4-word queue keeps input open.
module line_segment_clipper_unit #(
    parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lsc_seg_if.sink                    i_seg,
    lsc_clip_if.source                 o_clip,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lsc_pkg::APB_AW-1:0] paddr,
    input  logic [lsc_pkg::APB_DW-1:0] pwdata,
    output logic [lsc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import lsc_pkg::*;

    localparam int JW = 2 + 6 * (COORD_BITS + 2);

    logic [DIM_W-1:0] r_width, r_height;
    logic [FMT_W-1:0] r_format;
    logic             wr;
    logic [1:0]       idx;
    logic             push_v, push_r, pop_v, pop_r;
    logic [JW-1:0]    push_d, pop_d;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_format <= FORMAT_RST;
        end else if (wr) begin
            if (idx == REG_WIDTH) begin
                r_width <= pwdata[DIM_W-1:0];
            end
            if (idx == REG_HEIGHT) begin
                r_height <= pwdata[DIM_W-1:0];
            end
            if (idx == REG_FORMAT) begin
                r_format <= pwdata[FMT_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx == REG_WIDTH) begin
            prdata = APB_DW'(r_width);
        end else if (idx == REG_HEIGHT) begin
            prdata = APB_DW'(r_height);
        end else if (idx == REG_FORMAT) begin
            prdata = APB_DW'(r_format);
        end
    end

    lsc_front #(.N(COORD_BITS), .JW(JW)) u_front (
        .i_seg        (i_seg),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_fmt        (r_format),
        .o_push_valid (push_v),
        .o_push_data  (push_d),
        .i_push_ready (push_r)
    );

    lsc_fifo #(.W(JW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_v),
        .i_data  (push_d),
        .o_ready (push_r),
        .o_valid (pop_v),
        .o_data  (pop_d),
        .i_ready (pop_r)
    );

    lsc_back #(.N(COORD_BITS), .JW(JW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_width),
        .i_height (r_height),
        .i_valid  (pop_v),
        .i_data   (pop_d),
        .o_ready  (pop_r),
        .o_clip   (o_clip)
    );

    // a rejected or unsupported word carries zero coordinates
    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clip.valid && (o_clip.status != ST_OK) |->
            (o_clip.clip_x1 == '0) && (o_clip.clip_y1 == '0) &&
            (o_clip.clip_x2 == '0) && (o_clip.clip_y2 == '0))
        else $error("non-valid status with nonzero coordinates");

    a_width_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr && (idx == REG_WIDTH) |=> r_width == $past(pwdata[DIM_W-1:0]))
        else $error("raster width write lost");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop_v |-> push_r)
        else $error("queue refuses input while empty");

endmodule

// File: sv/lsc_front.sv
// Front end: orders endpoints, flags unsupported formats, rejects off-raster segments, builds the job word.
module lsc_front #(
    parameter int N  = 16,
    parameter int JW = 2 + 6 * (N + 2)
) (
    lsc_seg_if.sink                    i_seg,
    input  logic [lsc_pkg::DIM_W-1:0]  i_width,
    input  logic [lsc_pkg::DIM_W-1:0]  i_height,
    input  logic [lsc_pkg::FMT_W-1:0]  i_fmt,
    output logic                       o_push_valid,
    output logic [JW-1:0]              o_push_data,
    input  logic                       i_push_ready
);
    import lsc_pkg::*;

    localparam int CW = N + 2;

    typedef struct packed {
        t_status              st;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } t_job;

    logic signed [CW-1:0] ax, ay, bx, by, w, h, ymax, ymin;
    logic                 swap, unsup, rej;
    t_job                 job;

    always_comb begin
        ax    = CW'(i_seg.start_x);
        ay    = CW'(i_seg.start_y);
        bx    = CW'(i_seg.end_x);
        by    = CW'(i_seg.end_y);
        w     = $signed(CW'(i_width));
        h     = $signed(CW'(i_height));
        swap  = ax > bx;
        job.x1 = swap ? bx : ax;
        job.y1 = swap ? by : ay;
        job.x2 = swap ? ax : bx;
        job.y2 = swap ? ay : by;
        job.dx = job.x2 - job.x1;
        job.dy = job.y2 - job.y1;
        ymax  = (job.y1 > job.y2) ? job.y1 : job.y2;
        ymin  = (job.y1 < job.y2) ? job.y1 : job.y2;
        unsup = (i_fmt < FMT_15BIT) || (i_fmt > FMT_24BIT);
        rej   = (job.x2 < 0) || (job.x1 >= w) || (ymax < 0) || (ymin >= h);
        if (unsup) begin
            job.st = ST_UNSUP;
        end else if (rej) begin
            job.st = ST_REJECT;
        end else begin
            job.st = ST_OK;
        end
    end

    assign o_push_valid = i_seg.valid;
    assign o_push_data  = JW'(job);
    assign i_seg.ready  = i_push_ready;

endmodule

// File: sv/lsc_fifo.sv
// Small word queue between the front end and the clipping pipeline.
module lsc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready = r_cnt < (AW + 1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

endmodule

// File: sv/lsc_div.sv
// Pipelined restoring divider, two numerators over one divisor, truncating.
module lsc_div #(
    parameter int NW = 36,
    parameter int DW = 18,
    parameter int PW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num_a,
    input  logic signed [NW-1:0] i_num_b,
    input  logic signed [DW-1:0] i_den,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic signed [NW-1:0] o_quo_a,
    output logic signed [NW-1:0] o_quo_b,
    output logic [PW-1:0]        o_pay
);
    localparam int RW = DW + 1;

    function automatic logic [RW+NW-1:0] f_step(logic [RW-1:0] rem, logic [NW-1:0] q,
                                                 logic [DW-1:0] d);
        logic [RW-1:0] t;
        logic [RW-1:0] s;
        t = {rem[RW-2:0], q[NW-1]};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {s, q[NW-2:0], 1'b1};
        end
        return {t, q[NW-2:0], 1'b0};
    endfunction

    logic [RW-1:0] r_ra [NW];
    logic [RW-1:0] r_rb [NW];
    logic [NW-1:0] r_qa [NW];
    logic [NW-1:0] r_qb [NW];
    logic [DW-1:0] r_d  [NW];
    logic [PW-1:0] r_pay [NW];
    logic [NW-1:0] r_v, r_sa, r_sb, r_dz;

    logic [RW-1:0] s_ra [NW];
    logic [RW-1:0] s_rb [NW];
    logic [NW-1:0] s_qa [NW];
    logic [NW-1:0] s_qb [NW];
    logic [DW-1:0] s_d  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_src
        if (k == 0) begin : g_first
            assign s_ra[k] = '0;
            assign s_rb[k] = '0;
            assign s_qa[k] = i_num_a[NW-1] ? NW'(-i_num_a) : NW'(i_num_a);
            assign s_qb[k] = i_num_b[NW-1] ? NW'(-i_num_b) : NW'(i_num_b);
            assign s_d[k]  = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        end else begin : g_next
            assign s_ra[k] = r_ra[k-1];
            assign s_rb[k] = r_rb[k-1];
            assign s_qa[k] = r_qa[k-1];
            assign s_qb[k] = r_qb[k-1];
            assign s_d[k]  = r_d[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                {r_ra[k], r_qa[k]} <= f_step(s_ra[k], s_qa[k], s_d[k]);
                {r_rb[k], r_qb[k]} <= f_step(s_rb[k], s_qb[k], s_d[k]);
                r_d[k]             <= s_d[k];
                r_pay[k]           <= (k == 0) ? i_pay : r_pay[(k == 0) ? 0 : k - 1];
            end
            r_sa <= {r_sa[NW-2:0], i_num_a[NW-1] ^ i_den[DW-1]};
            r_sb <= {r_sb[NW-2:0], i_num_b[NW-1] ^ i_den[DW-1]};
            r_dz <= {r_dz[NW-2:0], i_den == '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-2:0], i_valid};
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_pay   = r_pay[NW-1];
    assign o_quo_a = r_dz[NW-1] ? '0 :
                     (r_sa[NW-1] ? -$signed(r_qa[NW-1]) : $signed(r_qa[NW-1]));
    assign o_quo_b = r_dz[NW-1] ? '0 :
                     (r_sb[NW-1] ? -$signed(r_qb[NW-1]) : $signed(r_qb[NW-1]));

endmodule

// File: sv/lsc_back.sv
// Back end: x clip then y clip, each a multiply stage and a divider pipeline.
module lsc_back #(
    parameter int N  = 16,
    parameter int JW = 2 + 6 * (N + 2)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lsc_pkg::DIM_W-1:0] i_width,
    input  logic [lsc_pkg::DIM_W-1:0] i_height,
    input  logic                      i_valid,
    input  logic [JW-1:0]             i_data,
    output logic                      o_ready,
    lsc_clip_if.source                o_clip
);
    import lsc_pkg::*;

    localparam int CW = N + 2;
    localparam int NW = 2 * CW;

    typedef struct packed {
        t_status              st;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [CW-1:0] x2;
        logic signed [CW-1:0] y2;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } t_job;

    typedef struct packed {
        t_job j;
        logic fa;
        logic fb;
    } t_pay1;

    typedef struct packed {
        t_job                 j;
        logic                 fc;
        logic                 fd;
        logic signed [CW-1:0] ty1;
        logic signed [CW-1:0] ty2;
    } t_pay2;

    logic                 en;
    logic signed [CW-1:0] w, h;
    t_job                 j0, j1n, j1;
    logic signed [CW-1:0] ma, mb, mc, md;

    logic                 r0_v;
    t_pay1                r0_pay;
    logic signed [NW-1:0] r0_na, r0_nb;

    logic                 d1_v;
    t_pay1                d1_pay;
    logic signed [NW-1:0] d1_qa, d1_qb;

    logic                 r1_v;
    t_job                 r1_job;

    logic                 r2_v;
    t_pay2                r2_pay, p2n;
    logic signed [NW-1:0] r2_nc, r2_nd;

    logic                 d2_v;
    t_pay2                d2_pay;
    logic signed [NW-1:0] d2_qc, d2_qd;

    logic                 r_ov;
    t_status              r_st;
    logic signed [N-1:0]  r_x1, r_y1, r_x2, r_y2;
    logic signed [CW-1:0] fx1, fy1, fx2, fy2;

    assign w       = $signed(CW'(i_width));
    assign h       = $signed(CW'(i_height));
    assign en      = !r_ov || o_clip.ready;
    assign o_ready = en;
    assign j0      = t_job'(i_data);

    // x clip numerators: distance past the edge times dy
    assign ma = -j0.x1;
    assign mb = w - CW'(1) - j0.x2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_pay.j  <= j0;
            r0_pay.fa <= (j0.st == ST_OK) && (j0.x1 < 0);
            r0_pay.fb <= (j0.st == ST_OK) && (j0.x2 >= w);
            r0_na     <= NW'(ma) * NW'(j0.dy);
            r0_nb     <= NW'(mb) * NW'(j0.dy);
        end
    end

    lsc_div #(.NW(NW), .DW(CW), .PW($bits(t_pay1))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_v),
        .i_num_a (r0_na),
        .i_num_b (r0_nb),
        .i_den   (r0_pay.j.dx),
        .i_pay   (r0_pay),
        .o_valid (d1_v),
        .o_quo_a (d1_qa),
        .o_quo_b (d1_qb),
        .o_pay   (d1_pay)
    );

    always_comb begin
        j1n = d1_pay.j;
        if (d1_pay.fa) begin
            j1n.y1 = d1_pay.j.y1 + d1_qa[CW-1:0];
            j1n.x1 = '0;
        end
        if (d1_pay.fb) begin
            j1n.y2 = d1_pay.j.y2 + d1_qb[CW-1:0];
            j1n.x2 = w - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_job <= j1n;
        end
    end

    // y clip: only with nonzero dy, towards the nearer horizontal edge
    always_comb begin
        j1      = r1_job;
        p2n.j   = j1;
        p2n.fc  = (j1.st == ST_OK) && (j1.dy != '0) && ((j1.y1 < 0) || (j1.y1 >= h));
        p2n.fd  = (j1.st == ST_OK) && (j1.dy != '0) && ((j1.y2 < 0) || (j1.y2 >= h));
        p2n.ty1 = (j1.y1 < 0) ? '0 : h - CW'(1);
        p2n.ty2 = (j1.y2 < 0) ? '0 : h - CW'(1);
        mc      = (j1.y1 < 0) ? -j1.y1 : h - CW'(1) - j1.y1;
        md      = (j1.y2 < 0) ? -j1.y2 : h - CW'(1) - j1.y2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pay <= p2n;
            r2_nc  <= NW'(mc) * NW'(j1.dx);
            r2_nd  <= NW'(md) * NW'(j1.dx);
        end
    end

    lsc_div #(.NW(NW), .DW(CW), .PW($bits(t_pay2))) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num_a (r2_nc),
        .i_num_b (r2_nd),
        .i_den   (r2_pay.j.dy),
        .i_pay   (r2_pay),
        .o_valid (d2_v),
        .o_quo_a (d2_qc),
        .o_quo_b (d2_qd),
        .o_pay   (d2_pay)
    );

    assign fx1 = d2_pay.fc ? d2_pay.j.x1 + d2_qc[CW-1:0] : d2_pay.j.x1;
    assign fy1 = d2_pay.fc ? d2_pay.ty1 : d2_pay.j.y1;
    assign fx2 = d2_pay.fd ? d2_pay.j.x2 + d2_qd[CW-1:0] : d2_pay.j.x2;
    assign fy2 = d2_pay.fd ? d2_pay.ty2 : d2_pay.j.y2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st <= d2_pay.j.st;
            r_x1 <= (d2_pay.j.st == ST_OK) ? fx1[N-1:0] : '0;
            r_y1 <= (d2_pay.j.st == ST_OK) ? fy1[N-1:0] : '0;
            r_x2 <= (d2_pay.j.st == ST_OK) ? fx2[N-1:0] : '0;
            r_y2 <= (d2_pay.j.st == ST_OK) ? fy2[N-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
            r1_v <= d1_v;
            r2_v <= r1_v;
            r_ov <= d2_v;
        end
    end

    assign o_clip.valid   = r_ov;
    assign o_clip.status  = r_st;
    assign o_clip.clip_x1 = r_x1;
    assign o_clip.clip_y1 = r_y1;
    assign o_clip.clip_x2 = r_x2;
    assign o_clip.clip_y2 = r_y2;

endmodule

// File: dv/line_segment_clipper_unit_tb.sv
// Self-checking testbench for the line segment clipper: directed table, random segments.
module line_segment_clipper_unit_tb;
    import lsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] t_coord;
    typedef struct packed {
        t_coord sx, sy, ex, ey;
    } t_seg;
    typedef struct packed {
        t_status st;
        t_coord x1, y1, x2, y2;
    } t_clip;
    typedef struct {
        t_seg  seg;
        logic  has_exp;
        t_clip exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    lsc_seg_if  #(.N(CB)) seg_ch ();
    lsc_clip_if #(.N(CB)) clip_ch ();

    line_segment_clipper_unit #(.COORD_BITS(CB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_seg(seg_ch.sink), .o_clip(clip_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // local register copies
    logic [DIM_W-1:0] cur_w = WIDTH_RST;
    logic [DIM_W-1:0] cur_h = HEIGHT_RST;
    logic [FMT_W-1:0] cur_fmt = FORMAT_RST;

    t_clip clip_q[$];
    int    n_bad = 0;
    int    cycles = 0;
    logic  no_idle = 1'b0;
    logic  hold_off = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint trunc_div(longint num, longint den);
        if (den == 0) return 0;
        return num / den;
    endfunction

    function automatic t_clip clip_segment(t_seg s);
        longint x1, y1, x2, y2, w, h, dx, dy, t;
        t_clip r;
        x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
        w = cur_w; h = cur_h;
        r = '0;
        if (cur_fmt < FMT_15BIT || cur_fmt > FMT_24BIT) begin
            r.st = ST_UNSUP;
            return r;
        end
        if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        if (x2 < 0 || x1 >= w || (y1 > y2 ? y1 : y2) < 0 || (y1 < y2 ? y1 : y2) >= h) begin
            r.st = ST_REJECT;
            return r;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        if (x1 < 0) begin
            y1 += trunc_div(-x1 * dy, dx); x1 = 0;
        end
        if (x2 >= w) begin
            y2 += trunc_div((w - x2 - 1) * dy, dx); x2 = w - 1;
        end
        if (dy != 0) begin
            if (y1 < 0) begin
                x1 += trunc_div(-y1 * dx, dy); y1 = 0;
            end else if (y1 >= h) begin
                x1 += trunc_div((h - y1 - 1) * dx, dy); y1 = h - 1;
            end
            if (y2 < 0) begin
                x2 += trunc_div(-y2 * dx, dy); y2 = 0;
            end else if (y2 >= h) begin
                x2 += trunc_div((h - y2 - 1) * dx, dy); y2 = h - 1;
            end
        end
        r.st = ST_OK;
        r.x1 = t_coord'(x1); r.y1 = t_coord'(y1);
        r.x2 = t_coord'(x2); r.y2 = t_coord'(y2);
        return r;
    endfunction

    // setup, access, then idle, so back-to-back writes never overlap
    task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WIDTH:  cur_w = val[DIM_W-1:0];
            REG_HEIGHT: cur_h = val[DIM_W-1:0];
            REG_FORMAT: cur_fmt = val[FMT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic idle_burst();
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_word(t_seg s, logic has_exp, t_clip exp);
        idle_burst();
        seg_ch.valid <= 1'b1;
        {seg_ch.start_x, seg_ch.start_y, seg_ch.end_x, seg_ch.end_y} <= s;
        do @(posedge i_clk); while (!seg_ch.ready);
        clip_q.push_back(has_exp ? exp : clip_segment(s));
    endtask

    task automatic drain();
        seg_ch.valid <= 1'b0;
        while (clip_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(int w);
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 40)) - 20;
            2: return t_coord'($urandom_range(0, 2 * w + 40)) - 20;
            default: return t_coord'($urandom_range(0, w + 400)) - 200;
        endcase
    endfunction

    // receiver: random stalls, one long hold-off
    initial begin
        clip_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                clip_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                clip_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                clip_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_clip got, want;
        if (i_rst_n && clip_ch.valid && clip_ch.ready) begin
            got = {t_status'(clip_ch.status), clip_ch.clip_x1, clip_ch.clip_y1,
                   clip_ch.clip_x2, clip_ch.clip_y2};
            if (clip_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected word %h", got);
            end else begin
                want = clip_q.pop_front();
                if (got.st !== want.st || got.x1 !== want.x1 || got.y1 !== want.y1
                    || got.x2 !== want.x2 || got.y2 !== want.y2) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch exp st=%0d %0d,%0d %0d,%0d got st=%0d %0d,%0d %0d,%0d",
                                 want.st, want.x1, want.y1, want.x2, want.y2,
                                 got.st, got.x1, got.y1, got.x2, got.y2);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_seg s;
        int   w;
        seg_ch.valid <= 1'b0;
        seg_ch.start_x <= '0; seg_ch.start_y <= '0;
        seg_ch.end_x <= '0; seg_ch.end_y <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset raster 640x480, 16-bit format
        rows = '{
            '{'{16'sd10, 16'sd20, 16'sd100, 16'sd200}, 1, '{ST_OK, 16'sd10, 16'sd20, 16'sd100, 16'sd200}},
            '{'{16'sd100, 16'sd200, 16'sd10, 16'sd20}, 1, '{ST_OK, 16'sd10, 16'sd20, 16'sd100, 16'sd200}},
            '{'{-16'sd5, 16'sd10, -16'sd1, 16'sd20}, 1, '{ST_REJECT, '0, '0, '0, '0}},
            '{'{16'sd640, 16'sd10, 16'sd700, 16'sd20}, 1, '{ST_REJECT, '0, '0, '0, '0}},
            '{'{16'sd10, -16'sd9, 16'sd20, -16'sd1}, 1, '{ST_REJECT, '0, '0, '0, '0}},
            '{'{16'sd10, 16'sd480, 16'sd20, 16'sd900}, 1, '{ST_REJECT, '0, '0, '0, '0}},
            '{'{16'sd0, 16'sd0, 16'sd639, 16'sd479}, 1, '{ST_OK, 16'sd0, 16'sd0, 16'sd639, 16'sd479}},
            '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 0, '0},
            '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 0, '0},
            '{'{-16'sd100, 16'sd50, 16'sd800, 16'sd50}, 1, '{ST_OK, 16'sd0, 16'sd50, 16'sd639, 16'sd50}},
            '{'{16'sd50, -16'sd100, 16'sd50, 16'sd900}, 0, '0},
            '{'{-16'sd50, 16'sd10, 16'sd10, -16'sd50}, 0, '0},
            '{'{16'sd600, 16'sd470, 16'sd700, 16'sd530}, 0, '0},
            '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 0, '0}
        };
        foreach (rows[i]) send_word(rows[i].seg, rows[i].has_exp, rows[i].exp);
        drain();
        reg_write(REG_FORMAT, 32'd0);
        send_word('{16'sd1, 16'sd1, 16'sd2, 16'sd2}, 1, '{ST_UNSUP, '0, '0, '0, '0});
        drain();
        reg_write(REG_FORMAT, 32'd7);
        send_word('{-16'sd32768, 16'sd1, 16'sd2, 16'sd32767}, 1, '{ST_UNSUP, '0, '0, '0, '0});
        drain();
        reg_write(REG_FORMAT, 32'd1);
        reg_write(REG_WIDTH, 32'd1);
        reg_write(REG_HEIGHT, 32'd1);
        send_word('{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{ST_OK, '0, '0, '0, '0});
        send_word('{-16'sd3, -16'sd3, 16'sd3, 16'sd3}, 0, '0);
        drain();

        // random phases over several raster settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(REG_WIDTH, 32'd4096); reg_write(REG_HEIGHT, 32'd4096);
                         reg_write(REG_FORMAT, 32'd3); end
                1: begin reg_write(REG_WIDTH, 32'd0); reg_write(REG_HEIGHT, 32'd8191);
                         reg_write(REG_FORMAT, 32'd2); end
                2: begin reg_write(REG_WIDTH, 32'd8191); reg_write(REG_HEIGHT, 32'd0); end
                3: reg_write(REG_FORMAT, 32'd4);
                4: begin reg_write(REG_WIDTH, $urandom_range(1, 4096));
                         reg_write(REG_HEIGHT, $urandom_range(1, 4096));
                         reg_write(REG_FORMAT, 32'd1); end
                default: begin reg_write(REG_WIDTH, 32'd640); reg_write(REG_HEIGHT, 32'd480);
                         reg_write(REG_FORMAT, 32'd2); end
            endcase
            w = (cur_w > cur_h ? cur_w : cur_h) + 1;
            if (ph == 4) hold_off = 1'b1;
            if (ph == 5) no_idle = 1'b1;
            for (int i = 0; i < (ph == 4 || ph == 5 ? 150 : 60); i++) begin
                s.sx = rand_coord(w); s.sy = rand_coord(w);
                s.ex = rand_coord(w); s.ey = rand_coord(w);
                send_word(s, 1'b0, '0);
            end
            drain();
        end

        if (n_bad == 0 && clip_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
